// File: rtl/apng_pkg.sv
// Package for the peak normalizing gain block: opcodes, gain modes,
// fixed-point constants and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package apng_pkg;

    // Input opcodes
    localparam logic [1:0] OP_SCAN   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_APPLY  = 2'd2;

    // Gain modes (the unused code falls back to unity)
    localparam logic [1:0] MODE_UNITY  = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    // Configuration register indexes
    localparam logic CFG_GAIN_MODE    = 1'b0;
    localparam logic CFG_MANUAL_RATIO = 1'b1;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 26;
    localparam int PROD_W   = SAMPLE_W + RATIO_W + 1;
    localparam int DIV_W    = 31;
    localparam int DIVCNT_W = 5;

    // -3 dB target in Q1.15 scaled to Q10.16
    localparam logic [DIV_W-1:0]    PEAK_NUM    = 31'd1520301996;
    // ratio that lifts a -20 dB floor to -3 dB
    localparam logic [RATIO_W-1:0]  NOISE_RATIO = 26'd463959;
    localparam logic [SAMPLE_W-1:0] NOISE_PEAK  = 16'd32;
    localparam logic [RATIO_W-1:0]  UNITY_RATIO = 26'd65536;

    typedef struct packed {
        logic scan;        // fold |sample| into the peak
        logic apply_load;  // capture sample and selected ratio
        logic mul;         // register the product
        logic sat;         // round, saturate, strobe the result
        logic div_load;    // load divider, clear the peak
        logic div_step;    // one quotient bit
        logic div_end;     // write quotient into the ratio
        logic noise_load;  // noise floor ratio, clear the peak
    } apng_cmd_t;

    typedef struct packed {
        logic auto_mode;   // gain mode is automatic
        logic peak_low;    // peak at or below the noise floor
        logic div_last;    // divider on its final step
    } apng_status_t;

endpackage

// File: rtl/apng_ctrl.sv
// Controller state machine for the peak normalizing gain block.
// Depends on apng_pkg for opcodes and the command/status structs.
`timescale 1ns / 1ps

module apng_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            opcode,
    input  apng_pkg::apng_status_t status,
    output apng_pkg::apng_cmd_t    cmd,
    output logic                  busy
);
    import apng_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_SCAN:
                        begin
                            cmd.scan = 1'b1;
                        end
                        OP_FINISH:
                        begin
                            if (status.auto_mode)
                            begin
                                if (status.peak_low)
                                begin
                                    cmd.noise_load = 1'b1;
                                end
                                else
                                begin
                                    cmd.div_load = 1'b1;
                                    state_next   = ST_DIV;
                                end
                            end
                        end
                        OP_APPLY:
                        begin
                            cmd.apply_load = 1'b1;
                            state_next     = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_mul_then_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_SAT)
        else $error("multiply not followed by saturate");

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !status.div_last) |=> state_reg == ST_DIV)
        else $error("divider left early");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_idle_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !start) |=> state_reg == ST_IDLE)
        else $error("left idle without a start");
`endif

endmodule

// File: rtl/apng_dpath.sv
// Datapath for the peak normalizing gain block: config registers, peak
// tracker, gain ratio, multiplier, saturation and radix-2 divider.
// Depends on apng_pkg for constants and the command/status structs.
`timescale 1ns / 1ps

module apng_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  apng_pkg::apng_cmd_t           cmd,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [apng_pkg::RATIO_W-1:0] cfg_data,
    input  logic signed [15:0]           sample_in,
    output apng_pkg::apng_status_t        status,
    output logic signed [15:0]           sample_out,
    output logic                         clipped,
    output logic                         done
);
    import apng_pkg::*;

    logic [1:0]              gain_mode_reg;
    logic [RATIO_W-1:0]      manual_ratio_reg;
    logic [SAMPLE_W-1:0]     peak_reg;
    logic [SAMPLE_W-1:0]     peak_next;
    logic [RATIO_W-1:0]      gain_ratio_reg;
    logic [RATIO_W-1:0]      gain_ratio_next;
    logic                    done_reg;

    logic signed [SAMPLE_W-1:0] op_sample_reg;
    logic [RATIO_W-1:0]         op_ratio_reg;
    logic [RATIO_W-1:0]         sel_ratio;
    logic signed [PROD_W-1:0]   product_reg;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [PROD_W-17:0]  scaled;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       clipped_reg;
    logic signed [SAMPLE_W-1:0] sat_value;
    logic                       sat_flag;

    logic [SAMPLE_W-1:0]     mag;
    logic [SAMPLE_W-1:0]     div_den_reg;
    logic [SAMPLE_W-1:0]     div_rem_reg;
    logic [DIV_W-1:0]        div_quo_reg;
    logic [DIVCNT_W-1:0]     div_cnt_reg;
    logic [SAMPLE_W:0]       partial;
    logic [SAMPLE_W+1:0]     diff;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_mode_reg    <= MODE_UNITY;
            manual_ratio_reg <= UNITY_RATIO;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GAIN_MODE)
            begin
                gain_mode_reg <= cfg_data[1:0];
            end
            else
            begin
                manual_ratio_reg <= cfg_data;
            end
        end
    end

    assign mag = sample_in[15] ? SAMPLE_W'(~sample_in + 16'sd1) : sample_in;

    always_comb
    begin
        peak_next       = peak_reg;
        gain_ratio_next = gain_ratio_reg;
        if (cmd.scan && (mag > peak_reg))
        begin
            peak_next = mag;
        end
        if (cmd.div_load || cmd.noise_load)
        begin
            peak_next = '0;
        end
        if (cmd.noise_load)
        begin
            gain_ratio_next = NOISE_RATIO;
        end
        if (cmd.div_end)
        begin
            gain_ratio_next = div_quo_reg[RATIO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            gain_ratio_reg <= UNITY_RATIO;
            done_reg       <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            peak_reg       <= peak_next;
            gain_ratio_reg <= gain_ratio_next;
            done_reg       <= cmd.sat;
            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // Ratio select: unused mode code behaves as unity
    always_comb
    begin
        case (gain_mode_reg)
            MODE_AUTO:   sel_ratio = gain_ratio_reg;
            MODE_MANUAL: sel_ratio = manual_ratio_reg;
            default:     sel_ratio = UNITY_RATIO;
        endcase
    end

    // Multiply, then round half up and saturate
    assign rounded = product_reg + PROD_W'(32768);
    assign scaled  = rounded[PROD_W-1:16];

    always_comb
    begin
        sat_value = scaled[SAMPLE_W-1:0];
        sat_flag  = 1'b0;
        if (scaled > (PROD_W-16)'(32767))
        begin
            sat_value = 16'sh7FFF;
            sat_flag  = 1'b1;
        end
        else if (scaled < -(PROD_W-16)'(32768))
        begin
            sat_value = -16'sh8000;
            sat_flag  = 1'b1;
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign partial = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, div_den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.apply_load)
        begin
            op_sample_reg <= sample_in;
            op_ratio_reg  <= sel_ratio;
        end
        if (cmd.mul)
        begin
            product_reg <= PROD_W'(op_sample_reg) * PROD_W'($signed({1'b0, op_ratio_reg}));
        end
        if (cmd.sat)
        begin
            sample_out_reg <= sat_value;
            clipped_reg    <= sat_flag;
        end
        if (cmd.div_load)
        begin
            div_den_reg <= peak_reg;
            div_rem_reg <= '0;
            div_quo_reg <= PEAK_NUM + DIV_W'(peak_reg[SAMPLE_W-1:1]);
        end
        else if (cmd.div_step)
        begin
            if (!diff[SAMPLE_W+1])
            begin
                div_rem_reg <= diff[SAMPLE_W-1:0];
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= partial[SAMPLE_W-1:0];
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign status.auto_mode = (gain_mode_reg == MODE_AUTO);
    assign status.peak_low  = (peak_reg <= NOISE_PEAK);
    assign status.div_last  = (div_cnt_reg == DIVCNT_W'(DIV_W - 1));

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;
    assign done       = done_reg;

endmodule

// File: rtl/audio_peak_normalize_gain_unit.sv
// Top level of the peak normalizing gain block: joins the controller
// and the datapath. Depends on apng_pkg, apng_ctrl and apng_dpath.
`timescale 1ns / 1ps

// Two-pass peak normalizing gain. Issue an item by raising start while busy
// is low. A scan (opcode 0) folds |sample_in| into the running peak and
// busy stays low. A finish (opcode 1) in automatic mode turns the peak into
// a Q10.16 ratio that puts the peak at -3 dB and clears the peak: at or
// below the noise floor (peak 32) the -20 dB floor ratio is loaded and busy
// stays low, otherwise a radix-2 restoring divider produces one quotient bit
// per cycle while busy stays high. Outside automatic mode a finish does
// nothing. An apply (opcode 2) holds busy through a multiply state and then
// a round-and-saturate state; the result is registered onto sample_out and
// clipped with done high for exactly one cycle, and a new item may be issued
// in that same cycle.
// There is no result backpressure: the receiver must take every strobe.
// Write gain_mode (index 0) and manual_ratio (index 1) only while idle;
// cfg_ready is always high.
module audio_peak_normalize_gain_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic signed [15:0]           sample_in,
    output logic                         done,
    output logic signed [15:0]           sample_out,
    output logic                         clipped,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [apng_pkg::RATIO_W-1:0] cfg_data
);
    import apng_pkg::*;

    apng_cmd_t    cmd;
    apng_status_t status;
    logic         cfg_we;

    // Config writes never stall, so always accept
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // Sequence each item; the FSM sees the start only while idle
    apng_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold peak, ratio and config; run multiply and divide
    apng_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .status     (status),
        .sample_out (sample_out),
        .clipped    (clipped),
        .done       (done)
    );

endmodule

// File: dv/audio_peak_normalize_gain_unit_tb.sv
// Self-checking testbench for audio_peak_normalize_gain_unit: a directed table, then random
// scan/finish/apply sequences under several gain settings and idle patterns.
// Depends on apng_pkg and the RTL of the gain unit.
`timescale 1ns / 1ps

module audio_peak_normalize_gain_unit_tb;

    import apng_pkg::*;

    // Codes the package leaves unnamed: the spare opcode and the spare gain mode
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // Gain arithmetic, Q1.15 samples and Q10.16 ratios
    localparam longint      TARGET_NUM  = 64'd1520301996;  // -3 dB target, Q1.15 -> Q10.16
    localparam logic [25:0] FLOOR_RATIO = 26'd463959;      // lifts a -20 dB peak to -3 dB
    localparam logic [15:0] FLOOR_PEAK  = 16'd32;
    localparam logic [25:0] UNITY_GAIN  = 26'd65536;
    localparam logic [25:0] RATIO_MAX   = 26'h3FFFFFF;

    // A finish can hold busy through a whole divide without a result; idle for
    // SETTLE_CYC before touching the registers and before the final verdict.
    localparam int SETTLE_CYC  = 40;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               clip;
    } gained_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         op;      // item opcode
        logic signed [15:0] smp;     // item sample
        logic               idx;     // register index for a write
        logic [25:0]        val;     // register data for a write
        bit                 typed;   // expected result given in the row
        logic signed [15:0] t_smp;
        logic               t_clip;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          opcode = OP_SCAN;
    logic signed [15:0]  sample_in = '0;
    logic                done;
    logic signed [15:0]  sample_out;
    logic                clipped;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_GAIN_MODE;
    logic [RATIO_W-1:0]  cfg_data = '0;

    // Predicted block state and configuration, kept at the block's widths
    logic [1:0]  cur_mode   = MODE_UNITY;
    logic [25:0] cur_manual = UNITY_GAIN;
    logic [15:0] peak_lvl   = '0;
    logic [25:0] live_ratio = UNITY_GAIN;

    gained_t     gained_q[$];   // gained samples still owed by the block
    gained_t     got_exp;
    int          err_cnt   = 0;
    int          n_items   = 0;
    int          n_results = 0;
    int          n_clips   = 0;
    int          n_ratios  = 0;
    int          n_floor   = 0;
    int unsigned idle_pct  = 0;

    // Directed table. Expected results are typed in where they are obvious
    // (unity gain, saturation, zero ratio or sample); the rest go through the predictor.
    stim_row_t stim_tab [32] = '{
        // reset state: unity gain passes both extremes untouched
        '{ROW_ITEM, OP_APPLY,  16'sd32767, 1'b0, 26'd0, 1'b1, 16'sd32767, 1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sh8000,  1'b0, 26'd0, 1'b1, 16'sh8000,  1'b0},
        // spare opcode is dropped
        '{ROW_ITEM, OP_UNUSED, 16'sh5A5A,  1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        // full-scale negative peak, then a finish outside automatic mode keeps it
        '{ROW_ITEM, OP_SCAN,   16'sh8000,  1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_GAIN_MODE, 26'(MODE_AUTO),
          1'b0, 16'sd0, 1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sh8000,  1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        // peak right at the noise floor selects the floor ratio
        '{ROW_ITEM, OP_SCAN,   16'sd32,    1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd1,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd32767, 1'b0, 26'd0, 1'b1, 16'sd32767, 1'b1},
        '{ROW_ITEM, OP_APPLY,  16'sh8000,  1'b0, 26'd0, 1'b1, 16'sh8000,  1'b1},
        // one step above the floor gives the largest divided ratio
        '{ROW_ITEM, OP_SCAN,   -16'sd33,   1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd0,     1'b0, 26'd0, 1'b1, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  -16'sd1,    1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        // finish right after a finish: cleared peak falls to the floor
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        // manual gain at both ends of the ratio range
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_MANUAL_RATIO, 26'd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_GAIN_MODE, 26'(MODE_MANUAL),
          1'b0, 16'sd0, 1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sh8000,  1'b0, 26'd0, 1'b1, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_SCAN,   16'sd12345, 1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_MANUAL_RATIO, RATIO_MAX, 1'b0, 16'sd0, 1'b0},
        '{ROW_ITEM, OP_APPLY,  -16'sd1,    1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd100,   1'b0, 26'd0, 1'b1, 16'sd32767, 1'b1},
        // spare mode behaves as unity
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_GAIN_MODE, 26'(MODE_RESERVED),
          1'b0, 16'sd0, 1'b0},
        '{ROW_ITEM, OP_APPLY,  -16'sd5,    1'b0, 26'd0, 1'b1, -16'sd5,    1'b0},
        // back to automatic: the floor ratio survived the mode changes
        '{ROW_CFG,  OP_SCAN,   16'sd0,     CFG_GAIN_MODE, 26'(MODE_AUTO),
          1'b0, 16'sd0, 1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd7,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_FINISH, 16'sd0,     1'b0, 26'd0, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, OP_APPLY,  16'sd32767, 1'b0, 26'd0, 1'b0, 16'sd0,     1'b0}
    };

    audio_peak_normalize_gain_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .sample_in  (sample_in),
        .done       (done),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the predicted state by one accepted item; report the gained
    // sample that an apply owes.
    function automatic void predict_gain(input logic [1:0] op, input logic signed [15:0] smp,
                                         output bit has_res, output gained_t res);
        int          mag;
        longint      prod;
        longint      q;
        logic [25:0] r;
        has_res = 1'b0;
        res     = '0;
        case (op)
            OP_SCAN:
            begin
                // full-scale negative folds in as 32768, which still fits
                mag = (smp < 0) ? -int'(smp) : int'(smp);
                if (mag > int'(peak_lvl))
                    peak_lvl = mag[15:0];
            end
            OP_FINISH:
            begin
                if (cur_mode == MODE_AUTO)
                begin
                    if (peak_lvl <= FLOOR_PEAK)
                    begin
                        live_ratio = FLOOR_RATIO;
                        n_floor++;
                    end
                    else
                    begin
                        live_ratio = 26'((TARGET_NUM + longint'(peak_lvl >> 1))
                                         / longint'(peak_lvl));
                    end
                    peak_lvl = '0;
                    n_ratios++;
                end
            end
            OP_APPLY:
            begin
                if (cur_mode == MODE_AUTO)
                    r = live_ratio;
                else if (cur_mode == MODE_MANUAL)
                    r = cur_manual;
                else
                    r = UNITY_GAIN;
                // round half up, then clamp to Q1.15
                prod = longint'(smp) * longint'(r) + 64'sd32768;
                q    = prod >>> 16;
                res.clip = 1'b1;
                if (q > 32767)
                    res.smp = 16'sd32767;
                else if (q < -32768)
                    res.smp = 16'sh8000;
                else
                begin
                    res.smp  = 16'(q);
                    res.clip = 1'b0;
                end
                has_res = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample(input int unsigned cls);
        int v;
        case (cls)
            0: v = int'($urandom_range(0, 80)) - 40;       // around the noise floor
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            2: v = int'($urandom_range(0, 8000)) - 4000;
            default: v = int'($urandom);
        endcase
        return 16'(v);
    endfunction

    // Issue one item. Call at a rising edge; return at the edge of the transfer,
    // with start still high so the next item can follow back to back.
    task automatic issue_item(input logic [1:0] op, input logic signed [15:0] smp,
                              input bit typed, input logic signed [15:0] t_smp,
                              input logic t_clip);
        bit      has_res;
        gained_t res;
        // hold off at random; each pass lowers start once per edge
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        sample_in <= smp;
        // busy only moves at rising edges, so its value mid-cycle is the one
        // seen at the next edge
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        predict_gain(op, smp, has_res, res);
        if (op != OP_UNUSED)
            n_items++;
        if (has_res)
        begin
            if (typed)
            begin
                res.smp  = t_smp;
                res.clip = t_clip;
            end
            gained_q.push_back(res);
        end
    endtask

    // Drop start and wait until every owed result is in and the divider is
    // done; leave extra room for a finish that owes nothing.
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (gained_q.size() != 0 || busy);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // One register write; call at a rising edge with the block idle.
    task automatic cfg_write(input logic idx, input logic [25:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        if (idx == CFG_GAIN_MODE)
            cur_mode = val[1:0];
        else
            cur_manual = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: done is high for exactly one cycle per apply, and the
    // receiver cannot stall, so sample mid-cycle and compare with the oldest
    // owed result.
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (gained_q.size() == 0)
            begin
                err_cnt++;
                $display("%t: result with nothing owed: sample_out=%0d clipped=%0b",
                         $time, $signed(sample_out), clipped);
            end
            else
            begin
                got_exp = gained_q.pop_front();
                n_results++;
                if (clipped)
                    n_clips++;
                if (sample_out !== got_exp.smp)
                begin
                    err_cnt++;
                    $display("%t: sample_out expected %0d actual %0d",
                             $time, $signed(got_exp.smp), $signed(sample_out));
                end
                if (clipped !== got_exp.clip)
                begin
                    err_cnt++;
                    $display("%t: clipped expected %0b actual %0b",
                             $time, got_exp.clip, clipped);
                end
            end
        end
    end

    initial
    begin
        bit               prev_cfg;
        int unsigned      idle_plan [4];
        logic [1:0]       phase_mode [N_PHASES];
        logic [25:0]      ratio_pick;
        int               phase_base;
        int unsigned      cls;
        int unsigned      n_run;
        logic [1:0]       op;

        idle_plan  = '{0, 71, 0, 33};
        phase_mode = '{MODE_AUTO, MODE_MANUAL, MODE_AUTO, MODE_UNITY,
                       MODE_AUTO, MODE_RESERVED, MODE_MANUAL, MODE_AUTO};
        prev_cfg   = 1'b0;

        // Hold reset, then release it on a rising edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back; drain before each group of writes.
        idle_pct = 0;
        foreach (stim_tab[i])
        begin
            if (stim_tab[i].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    settle();
                cfg_write(stim_tab[i].idx, stim_tab[i].val);
            end
            else
            begin
                issue_item(stim_tab[i].op, stim_tab[i].smp, stim_tab[i].typed,
                           stim_tab[i].t_smp, stim_tab[i].t_clip);
            end
            prev_cfg = (stim_tab[i].kind == ROW_CFG);
        end

        // Random phases. Each one drains the block, rewrites both registers and
        // runs mostly well-formed passes (scan burst, finish, apply burst) with
        // some loose items mixed in, under its own idle pattern.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            case ($urandom_range(0, 4))
                0: ratio_pick = '0;
                1: ratio_pick = RATIO_MAX;
                2: ratio_pick = UNITY_GAIN;
                3: ratio_pick = 26'($urandom_range(0, 200000));
                default: ratio_pick = 26'($urandom);
            endcase
            cfg_write(CFG_GAIN_MODE, 26'(phase_mode[ph]));
            cfg_write(CFG_MANUAL_RATIO, ratio_pick);
            idle_pct   = idle_plan[ph % 4];
            phase_base = n_items;
            while (n_items - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // one normalize pass at a random loudness class
                    cls   = $urandom_range(0, 3);
                    n_run = $urandom_range(1, 12);
                    repeat (n_run)
                        issue_item(OP_SCAN, pick_sample(cls), 1'b0, '0, 1'b0);
                    issue_item(OP_FINISH, 16'($urandom), 1'b0, '0, 1'b0);
                    n_run = $urandom_range(1, 10);
                    repeat (n_run)
                        issue_item(OP_APPLY, pick_sample($urandom_range(0, 3)),
                                   1'b0, '0, 1'b0);
                end
                else
                begin
                    // loose item, spare opcode included
                    op = 2'($urandom_range(0, 3));
                    issue_item(op, pick_sample($urandom_range(0, 3)), 1'b0, '0, 1'b0);
                end
            end
        end

        // Drain and give the block time to produce anything stray.
        settle();

        $display("Ran %0d items over %0d random phases: %0d gained samples checked, %0d clipped",
                 n_items, N_PHASES, n_results, n_clips);
        $display("Automatic finishes loaded %0d ratios, %0d of them from the noise floor",
                 n_ratios, n_floor);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Timeout waiting on the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule
